FILE: rtl/pov_column_scanner_defines.svh
// assertion macros shared by the column scanner rtl
`ifndef POV_COLUMN_SCANNER_DEFINES_SVH
`define POV_COLUMN_SCANNER_DEFINES_SVH
`ifndef ASSERT_OFF
// invariant checked on every edge outside reset
`define POV_ASSERT(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);
// condition that must hold whenever the trigger holds
`define POV_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);
`else
`define POV_ASSERT(lbl, expr, msg)
`define POV_ASSERT_IMPLY(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/pov_cs_pkg.sv
// types and constants of the column scanner
package pov_cs_pkg;

   // port widths
   localparam int OP_W        = 2;
   localparam int WADDR_W     = 10;
   localparam int BYTE_W      = 8;
   localparam int USEC_W      = 16;
   localparam int GLYPHS_W    = 7;
   localparam int SCROLL_W    = 10;
   localparam int PHASE_W     = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // largest glyph count the register can hold
   localparam int GLYPHS_MAX = 2 ** GLYPHS_W - 1;

   // input operations
   localparam logic [OP_W-1:0] OP_SENSOR = 2'd0;
   localparam logic [OP_W-1:0] OP_COLUMN = 2'd1;
   localparam logic [OP_W-1:0] OP_WRITE  = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_SYNC_LEFT   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SYNC_RIGHT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ON_TIME     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SPLIT       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SCROLL      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_TEXT_GLYPHS = 3'd5;

   // rotation phases
   localparam logic [PHASE_W-1:0] PHASE_IDLE      = 3'd0;
   localparam logic [PHASE_W-1:0] PHASE_LEFT      = 3'd1;
   localparam logic [PHASE_W-1:0] PHASE_LEFT_DONE = 3'd2;
   localparam logic [PHASE_W-1:0] PHASE_RIGHT     = 3'd3;
   localparam logic [PHASE_W-1:0] PHASE_MAX       = 3'd7;

   // result kinds and sides
   localparam logic KIND_COLUMN = 1'b0;
   localparam logic KIND_BLANK  = 1'b1;
   localparam logic SIDE_LEFT   = 1'b0;
   localparam logic SIDE_RIGHT  = 1'b1;

   // blanking latch delay in microseconds
   localparam logic [USEC_W-1:0] BLANK_DELAY = 16'd300;

   // output queue
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = PTR_W + 1;

   // one result word
   typedef struct packed {
      logic              kind;
      logic              side;
      logic [BYTE_W-1:0] first_byte;
      logic [BYTE_W-1:0] second_byte;
      logic [USEC_W-1:0] pre_delay;
      logic [USEC_W-1:0] on_time;
      logic              drive_left;
      logic              drive_right;
      logic              last;
   } result_type;

endpackage

FILE: rtl/pov_cs_ram.sv
// generic single-write dual-read ram with registered read data
module pov_cs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // write port and two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

FILE: rtl/pov_column_scanner.sv
// Column scanner top level: frame-buffer ram, phase/index/scroll state and result queue.
// A column slot's words are registered in the ram read ports and the read stage, then written
// into the result queue, whose head drives the result port.
// Throughput: one item per cycle; the input stalls while the 4-entry queue, counting the
// words in flight, has room for fewer than two; a side-ending slot pushes a blank word too.
// Reset (synchronous): clears control state and config, then a clearing pass writes zero
// to every frame-buffer byte with req_stall high; csr writes go on.
`include "pov_column_scanner_defines.svh"

module pov_column_scanner #(
   parameter int BUFFER_BYTES = 1024,
   parameter int FRAME_BYTES  = 160,
   parameter int GLYPH_BYTES  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // item input
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [pov_cs_pkg::OP_W-1:0]         req_op,
   input  logic [pov_cs_pkg::WADDR_W-1:0]      req_write_address,
   input  logic [pov_cs_pkg::BYTE_W-1:0]       req_write_data,
   // result output
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_kind,
   output logic                                rsp_side,
   output logic [pov_cs_pkg::BYTE_W-1:0]       rsp_first_byte,
   output logic [pov_cs_pkg::BYTE_W-1:0]       rsp_second_byte,
   output logic [pov_cs_pkg::USEC_W-1:0]       rsp_pre_delay,
   output logic [pov_cs_pkg::USEC_W-1:0]       rsp_on_time,
   output logic                                rsp_drive_left,
   output logic                                rsp_drive_right,
   output logic                                rsp_last,
   // register writes
   input  logic                                csr_write_enable,
   input  logic [pov_cs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pov_cs_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   localparam int AW        = $clog2(BUFFER_BYTES);
   localparam int IDX_W     = $clog2(FRAME_BYTES + 2);
   localparam int WRAP_W    = $clog2(GLYPH_BYTES * pov_cs_pkg::GLYPHS_MAX + 1);
   localparam int SCROLL_W  = pov_cs_pkg::SCROLL_W;
   localparam int CMP_W     = (WRAP_W > SCROLL_W) ? WRAP_W : SCROLL_W;
   localparam int WADDR_W   = pov_cs_pkg::WADDR_W;
   localparam int RED_W     = (AW > WADDR_W + 1) ? AW : WADDR_W + 1;
   localparam int RED_STEPS = (BUFFER_BYTES >= 2 ** WADDR_W) ? 0 :
                              $clog2((2 ** WADDR_W + BUFFER_BYTES - 1) / BUFFER_BYTES);
   localparam int PTR_W     = pov_cs_pkg::PTR_W;
   localparam int CNT_W     = pov_cs_pkg::CNT_W;

   // configuration registers
   logic [pov_cs_pkg::USEC_W-1:0]   sync_left_ff;
   logic [pov_cs_pkg::USEC_W-1:0]   sync_right_ff;
   logic [pov_cs_pkg::USEC_W-1:0]   on_time_ff;
   logic                            split_enable_ff;
   logic                            scroll_enable_ff;
   logic [pov_cs_pkg::GLYPHS_W-1:0] text_glyphs_ff;

   // scan state
   logic [pov_cs_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [IDX_W-1:0]               byte_index_ff, byte_index_in;
   logic [SCROLL_W-1:0]            scroll_ff, scroll_in;
   logic [AW-1:0]                  scroll_mod_ff, scroll_mod_in;
   logic [AW-1:0]                  base_mod_ff, base_mod_in;
   logic                           clearing_ff, clearing_in;
   logic [AW-1:0]                  clear_addr_ff, clear_addr_in;

   // read stage
   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_done_ff, s1_done_in;
   pov_cs_pkg::result_type s1_col_ff, s1_col_in;

   // result queue
   pov_cs_pkg::result_type fifo_ff [pov_cs_pkg::FIFO_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [PTR_W-1:0]       wr_ptr_next;
   logic [1:0]             push_n;
   logic                   pop;
   pov_cs_pkg::result_type col_word;
   pov_cs_pkg::result_type blank_word;
   pov_cs_pkg::result_type head_word;

   // datapath signals
   logic                      req_accept;
   logic                      col_fire;
   logic                      side;
   logic [IDX_W-1:0]          idx_step;
   logic                      frame_done;
   logic [AW:0]               base_sum;
   logic [AW-1:0]             base_step;
   logic [AW:0]               base_one_sum;
   logic [AW-1:0]             base_plus_one;
   logic [WRAP_W-1:0]         wrap_point;
   logic                      wrap_hit;
   logic [SCROLL_W-1:0]       scroll_base;
   logic [AW-1:0]             smod_base;
   logic [SCROLL_W:0]         scroll_sum;
   logic [AW:0]               smod_sum;
   logic [SCROLL_W-1:0]       scroll_new;
   logic [AW-1:0]             smod_new;
   logic [RED_W-1:0]          wr_acc;
   logic                      ram_wr_en;
   logic [AW-1:0]             ram_wr_addr;
   logic [pov_cs_pkg::BYTE_W-1:0] ram_wr_data;
   logic [pov_cs_pkg::BYTE_W-1:0] rd_byte_a;
   logic [pov_cs_pkg::BYTE_W-1:0] rd_byte_b;

   assign req_accept = req_valid && !req_stall;
   assign side       = (phase_ff == pov_cs_pkg::PHASE_RIGHT);
   assign col_fire   = req_accept && (req_op == pov_cs_pkg::OP_COLUMN) &&
                       ((phase_ff == pov_cs_pkg::PHASE_LEFT) ||
                        (phase_ff == pov_cs_pkg::PHASE_RIGHT));

   // byte index step and end of side
   assign idx_step   = byte_index_ff + IDX_W'(2);
   assign frame_done = (idx_step >= IDX_W'(FRAME_BYTES));

   // buffer address of the pair, kept reduced modulo the buffer size
   assign base_sum      = {1'b0, base_mod_ff} + (AW+1)'(2);
   assign base_step     = (base_sum >= (AW+1)'(BUFFER_BYTES)) ?
                          AW'(base_sum - (AW+1)'(BUFFER_BYTES)) : AW'(base_sum);
   assign base_one_sum  = {1'b0, base_mod_ff} + (AW+1)'(1);
   assign base_plus_one = (base_one_sum == (AW+1)'(BUFFER_BYTES)) ? '0 : AW'(base_one_sum);

   // scroll wrap point and step after the right side
   assign wrap_point  = WRAP_W'(GLYPH_BYTES) * WRAP_W'(text_glyphs_ff);
   assign wrap_hit    = (CMP_W'(scroll_ff) == CMP_W'(wrap_point));
   assign scroll_base = wrap_hit ? '0 : scroll_ff;
   assign smod_base   = wrap_hit ? '0 : scroll_mod_ff;
   assign scroll_sum  = {1'b0, scroll_base} + (SCROLL_W+1)'(2);
   assign smod_sum    = {1'b0, smod_base} + (AW+1)'(2);

   always_comb begin
      scroll_new = scroll_base;
      smod_new   = smod_base;
      if (scroll_enable_ff) begin
         scroll_new = scroll_sum[SCROLL_W-1:0];
         if (scroll_sum[SCROLL_W]) begin
            // wrapped past the top of the offset range: value is tiny
            smod_new = AW'(scroll_sum[1:0]);
         end else if (smod_sum >= (AW+1)'(BUFFER_BYTES)) begin
            smod_new = AW'(smod_sum - (AW+1)'(BUFFER_BYTES));
         end else begin
            smod_new = AW'(smod_sum);
         end
      end
   end

   // write address modulo the buffer size by binary subtract steps
   always_comb begin
      wr_acc = RED_W'(req_write_address);
      for (int k = RED_STEPS - 1; k >= 0; k--) begin
         if (wr_acc >= (RED_W'(BUFFER_BYTES) << k)) begin
            wr_acc = wr_acc - (RED_W'(BUFFER_BYTES) << k);
         end
      end
   end

   // scan state next values
   always_comb begin
      phase_in      = phase_ff;
      byte_index_in = byte_index_ff;
      scroll_in     = scroll_ff;
      scroll_mod_in = scroll_mod_ff;
      base_mod_in   = base_mod_ff;
      if (req_accept && (req_op == pov_cs_pkg::OP_SENSOR) &&
          (phase_ff != pov_cs_pkg::PHASE_MAX)) begin
         phase_in = phase_ff + pov_cs_pkg::PHASE_W'(1);
      end
      if (col_fire) begin
         if (frame_done) begin
            byte_index_in = '0;
            if (side == pov_cs_pkg::SIDE_RIGHT) begin
               phase_in      = pov_cs_pkg::PHASE_IDLE;
               scroll_in     = scroll_new;
               scroll_mod_in = smod_new;
               base_mod_in   = smod_new;
            end else begin
               phase_in    = pov_cs_pkg::PHASE_LEFT_DONE;
               base_mod_in = scroll_mod_ff;
            end
         end else begin
            byte_index_in = idx_step;
            base_mod_in   = base_step;
         end
      end
   end

   // clearing pass after reset
   always_comb begin
      clearing_in   = clearing_ff;
      clear_addr_in = clear_addr_ff;
      if (clearing_ff) begin
         clear_addr_in = clear_addr_ff + AW'(1);
         if (clear_addr_ff == AW'(BUFFER_BYTES - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   // ram write mux: clearing pass or byte write word
   assign ram_wr_en   = clearing_ff || (req_accept && (req_op == pov_cs_pkg::OP_WRITE));
   assign ram_wr_addr = clearing_ff ? clear_addr_ff : wr_acc[AW-1:0];
   assign ram_wr_data = clearing_ff ? '0 : req_write_data;

   // column-slot reads and writes never share a cycle, so the next slot sees the last write
   pov_cs_ram #(
      .WIDTH (pov_cs_pkg::BYTE_W),
      .DEPTH (BUFFER_BYTES)
   ) u_frame_ram (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_addr_a (base_mod_ff),
      .rd_data_a (rd_byte_a),
      .rd_addr_b (base_plus_one),
      .rd_data_b (rd_byte_b)
   );

   // column word fields while the read is in flight
   always_comb begin
      s1_valid_in           = col_fire;
      s1_done_in            = frame_done;
      s1_col_in.kind        = pov_cs_pkg::KIND_COLUMN;
      s1_col_in.side        = side;
      s1_col_in.first_byte  = '0;
      s1_col_in.second_byte = '0;
      s1_col_in.pre_delay   = '0;
      if (byte_index_ff == '0) begin
         s1_col_in.pre_delay = side ? sync_right_ff : sync_left_ff;
      end
      s1_col_in.on_time     = on_time_ff;
      s1_col_in.drive_left  = side ? split_enable_ff : 1'b1;
      s1_col_in.drive_right = side ? 1'b1 : split_enable_ff;
      s1_col_in.last        = !frame_done;
   end

   // words pushed into the queue
   always_comb begin
      col_word             = s1_col_ff;
      col_word.first_byte  = rd_byte_a;
      col_word.second_byte = rd_byte_b;
      blank_word.kind        = pov_cs_pkg::KIND_BLANK;
      blank_word.side        = s1_col_ff.side;
      blank_word.first_byte  = '0;
      blank_word.second_byte = '0;
      blank_word.pre_delay   = pov_cs_pkg::BLANK_DELAY;
      blank_word.on_time     = '0;
      blank_word.drive_left  = 1'b1;
      blank_word.drive_right = 1'b1;
      blank_word.last        = 1'b1;
   end

   // queue bookkeeping
   assign push_n      = s1_valid_ff ? (s1_done_ff ? 2'd2 : 2'd1) : 2'd0;
   assign pop         = rsp_valid && !rsp_stall;
   assign wr_ptr_next = wr_ptr_ff + PTR_W'(1);
   assign wr_ptr_in   = wr_ptr_ff + PTR_W'(push_n);
   assign rd_ptr_in   = rd_ptr_ff + PTR_W'(pop);
   assign count_in    = count_ff + CNT_W'(push_n) - CNT_W'(pop);

   // room for two words counting the words in flight
   assign req_stall = clearing_ff ||
                      ((count_ff + CNT_W'(push_n)) > CNT_W'(pov_cs_pkg::FIFO_DEPTH - 2));

   // output port
   assign head_word       = fifo_ff[rd_ptr_ff];
   assign rsp_valid       = (count_ff != '0);
   assign rsp_kind        = head_word.kind;
   assign rsp_side        = head_word.side;
   assign rsp_first_byte  = head_word.first_byte;
   assign rsp_second_byte = head_word.second_byte;
   assign rsp_pre_delay   = head_word.pre_delay;
   assign rsp_on_time     = head_word.on_time;
   assign rsp_drive_left  = head_word.drive_left;
   assign rsp_drive_right = head_word.drive_right;
   assign rsp_last        = head_word.last;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_left_ff     <= '0;
         sync_right_ff    <= '0;
         on_time_ff       <= '0;
         split_enable_ff  <= 1'b0;
         scroll_enable_ff <= 1'b0;
         text_glyphs_ff   <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            pov_cs_pkg::REG_SYNC_LEFT:   sync_left_ff     <= csr_write_data;
            pov_cs_pkg::REG_SYNC_RIGHT:  sync_right_ff    <= csr_write_data;
            pov_cs_pkg::REG_ON_TIME:     on_time_ff       <= csr_write_data;
            pov_cs_pkg::REG_SPLIT:       split_enable_ff  <= csr_write_data[0];
            pov_cs_pkg::REG_SCROLL:      scroll_enable_ff <= csr_write_data[0];
            pov_cs_pkg::REG_TEXT_GLYPHS:
               text_glyphs_ff <= csr_write_data[pov_cs_pkg::GLYPHS_W-1:0];
            default: ;
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= pov_cs_pkg::PHASE_IDLE;
         byte_index_ff <= '0;
         scroll_ff     <= '0;
         scroll_mod_ff <= '0;
         base_mod_ff   <= '0;
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
         s1_valid_ff   <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         phase_ff      <= phase_in;
         byte_index_ff <= byte_index_in;
         scroll_ff     <= scroll_in;
         scroll_mod_ff <= scroll_mod_in;
         base_mod_ff   <= base_mod_in;
         clearing_ff   <= clearing_in;
         clear_addr_ff <= clear_addr_in;
         s1_valid_ff   <= s1_valid_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_done_ff <= s1_done_in;
      s1_col_ff  <= s1_col_in;
      if (s1_valid_ff) begin
         fifo_ff[wr_ptr_ff] <= col_word;
         if (s1_done_ff) begin
            fifo_ff[wr_ptr_next] <= blank_word;
         end
      end
   end

   // checks
   `POV_ASSERT(a_fifo_bound, count_ff <= CNT_W'(pov_cs_pkg::FIFO_DEPTH), "result queue overflow")
   `POV_ASSERT(a_addr_state, !byte_index_ff[0] && ({1'b0, base_mod_ff} < (AW+1)'(BUFFER_BYTES)), "bad scan address state")
   `POV_ASSERT_IMPLY(a_read_from_slot, s1_valid_ff, $past(col_fire), "read stage without a column slot")
   `POV_ASSERT_IMPLY(a_side_end, s1_valid_ff && s1_done_ff, (byte_index_ff == '0) && ((phase_ff == pov_cs_pkg::PHASE_LEFT_DONE) || (phase_ff == pov_cs_pkg::PHASE_IDLE)), "side end left stale state")

endmodule
